// ===== hdl/vwpe_pkg.sv =====
// shared types, constants and tables of the video word pixel expander
package vwpe_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int COLOR_W    = 24;

   localparam logic [COLOR_W-1:0] HALF_MASK    = 24'hFEFEFF;
   localparam logic [COLOR_W-1:0] QUARTER_MASK = 24'hFCFCFF;

   localparam logic [2:0] MODE_1X      = 3'd0;
   localparam logic [2:0] MODE_HALF    = 3'd1;
   localparam logic [2:0] MODE_DOUBLE  = 3'd2;
   localparam logic [2:0] MODE_BLEND25 = 3'd3;
   localparam logic [2:0] MODE_BLEND3  = 3'd4;

   typedef enum logic [1:0] {
      REG_SCREEN_MODE,
      REG_HIRES_ON,
      REG_BORDER_COLOR,
      REG_BLINK_PHASE
   } reg_index_type;

   typedef enum logic [2:0] {
      PLAN_PASS,
      PLAN_DOUBLE,
      PLAN_TRIPLE,
      PLAN_N_BLEND,
      PLAN_H_HALF,
      PLAN_H_BLEND3,
      PLAN_H_BLEND4,
      PLAN_BORDER
   } plan_type;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_HALF,
      OP_QUARTER
   } op_type;

   typedef struct packed {
      logic [2:0] screen_mode;
      logic       hires_on;
      logic [2:0] border_color;
      logic       blink_phase;
   } cfg_type;

   // one decoded video item, pixel bits in display order (bit 0 first)
   typedef struct packed {
      plan_type           plan;
      logic [7:0]         bits;
      logic [COLOR_W-1:0] ink;
      logic [COLOR_W-1:0] paper;
   } item_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] oa;
      logic [1:0] ob;
      logic       group_end;
   } step_type;

   // two colors and the mix to apply, plus the end-of-item flag
   typedef struct packed {
      logic [COLOR_W-1:0] ca;
      logic [COLOR_W-1:0] cb;
      op_type             op;
      logic               last;
   } tap_type;

   function automatic logic [COLOR_W-1:0] palette(input logic [4:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         5'd0:  c = 24'h000000;
         5'd1:  c = 24'h0000FF;
         5'd2:  c = 24'hFF0000;
         5'd3:  c = 24'hFF00FF;
         5'd4:  c = 24'h00FF00;
         5'd5:  c = 24'h00FFFF;
         5'd6:  c = 24'hFFFF00;
         5'd7:  c = 24'hFFFFFF;
         5'd8:  c = 24'h000000;
         5'd9:  c = 24'h00007F;
         5'd10: c = 24'h7F0000;
         5'd11: c = 24'h7F007F;
         5'd12: c = 24'h007F00;
         5'd13: c = 24'h007F7F;
         5'd14: c = 24'h7F7F00;
         5'd15: c = 24'h7F7F7F;
         5'd16: c = 24'h101010;
         5'd17: c = 24'h0000EF;
         5'd18: c = 24'hEF0000;
         5'd19: c = 24'hEF00EF;
         5'd20: c = 24'h00EF00;
         5'd21: c = 24'h00EFEF;
         5'd22: c = 24'hEFEF00;
         5'd23: c = 24'hEFEFEF;
         default: c = '0;
      endcase
      return c;
   endfunction

   // source pixels advanced per group
   function automatic logic [2:0] plan_stride(input plan_type plan);
      logic [2:0] s;
      case (plan)
         PLAN_N_BLEND, PLAN_H_HALF, PLAN_H_BLEND4: s = 3'd2;
         PLAN_H_BLEND3:                            s = 3'd4;
         default:                                  s = 3'd1;
      endcase
      return s;
   endfunction

   // what one output pixel is made of, by plan and phase within the group
   function automatic step_type plan_step(input plan_type plan, input logic [2:0] phase);
      step_type st;
      st = '{op: OP_PASS, oa: 2'd0, ob: 2'd0, group_end: 1'b1};
      case (plan)
         PLAN_DOUBLE: begin
            st.group_end = (phase == 3'd1);
         end
         PLAN_TRIPLE: begin
            st.group_end = (phase == 3'd2);
         end
         PLAN_N_BLEND: begin
            st.group_end = (phase == 3'd4);
            case (phase)
               3'd2: begin
                  st.op = OP_HALF;
                  st.ob = 2'd1;
               end
               3'd3, 3'd4: begin
                  st.oa = 2'd1;
               end
               default: ;
            endcase
         end
         PLAN_H_HALF: begin
            st.op = OP_HALF;
            st.ob = 2'd1;
         end
         PLAN_H_BLEND3: begin
            st.group_end = (phase == 3'd4);
            case (phase)
               3'd1: begin
                  st.op = OP_QUARTER;
                  st.ob = 2'd1;
               end
               3'd2: begin
                  st.op = OP_HALF;
                  st.oa = 2'd1;
                  st.ob = 2'd2;
               end
               3'd3: begin
                  st.op = OP_QUARTER;
                  st.oa = 2'd3;
                  st.ob = 2'd2;
               end
               3'd4: begin
                  st.oa = 2'd3;
               end
               default: ;
            endcase
         end
         PLAN_H_BLEND4: begin
            st.group_end = (phase == 3'd2);
            case (phase)
               3'd1: begin
                  st.op = OP_HALF;
                  st.ob = 2'd1;
               end
               3'd2: begin
                  st.oa = 2'd1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return st;
   endfunction

endpackage

// ===== hdl/vwpe_csr.sv =====
// configuration registers on the apb-style port
module vwpe_csr import vwpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_SCREEN_MODE:  cfg_in.screen_mode  = pwdata[2:0];
            REG_HIRES_ON:     cfg_in.hires_on     = pwdata[0];
            REG_BORDER_COLOR: cfg_in.border_color = pwdata[2:0];
            REG_BLINK_PHASE:  cfg_in.blink_phase  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SCREEN_MODE:  prdata = {29'd0, cfg_ff.screen_mode};
         REG_HIRES_ON:     prdata = {31'd0, cfg_ff.hires_on};
         REG_BORDER_COLOR: prdata = {29'd0, cfg_ff.border_color};
         REG_BLINK_PHASE:  prdata = {31'd0, cfg_ff.blink_phase};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/vwpe_decode.sv =====
// input stage: palette lookup, blink swap and expansion plan select
module vwpe_decode import vwpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        load,
   input  logic        func,
   input  logic [15:0] video_word,
   input  logic        take,
   output logic        a_valid,
   output item_type    item
);

   logic     a_valid_ff;
   logic     a_valid_in;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      item_in = '0;
      for (int i = 0; i < 8; i++) begin
         item_in.bits[i] = video_word[7-i];
      end
      if (func) begin
         item_in.plan  = PLAN_BORDER;
         item_in.bits  = '0;
         item_in.paper = palette({2'b10, cfg.border_color});
         item_in.ink   = item_in.paper;
      end else if (cfg.hires_on) begin
         item_in.paper = palette({2'b00, cfg.border_color});
         item_in.ink   = palette({2'b00, cfg.border_color ^ 3'd7});
         case (cfg.screen_mode)
            MODE_HALF:    item_in.plan = PLAN_H_HALF;
            MODE_BLEND25: item_in.plan = PLAN_H_BLEND3;
            MODE_BLEND3:  item_in.plan = PLAN_H_BLEND4;
            default:      item_in.plan = PLAN_PASS;
         endcase
      end else begin
         if (video_word[15] && cfg.blink_phase) begin
            item_in.paper = palette({2'b00, video_word[10:8]});
            item_in.ink   = palette({2'b00, video_word[13:11]});
         end else begin
            item_in.paper = palette({2'b00, video_word[13:11]});
            item_in.ink   = palette({2'b00, video_word[10:8]});
         end
         case (cfg.screen_mode)
            MODE_DOUBLE:  item_in.plan = PLAN_DOUBLE;
            MODE_BLEND25: item_in.plan = PLAN_N_BLEND;
            MODE_BLEND3:  item_in.plan = PLAN_TRIPLE;
            default:      item_in.plan = PLAN_PASS;
         endcase
      end
   end

   assign a_valid_in = load ? 1'b1 : (take ? 1'b0 : a_valid_ff);
   assign a_valid    = a_valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hdl/vwpe_seq.sv =====
// expansion sequencer: walks the plan one output pixel per cycle
module vwpe_seq import vwpe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     a_valid,
   input  item_type item,
   output logic     b_free,
   output logic     c_valid,
   output tap_type  tap
);

   logic       b_valid_ff;
   logic       b_valid_in;
   item_type   b_item_ff;
   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic [2:0] base_ff;
   logic [2:0] base_in;
   logic       c_valid_ff;
   tap_type    tap_ff;
   tap_type    tap_in;

   step_type   st;
   logic [3:0] next_base;
   logic       item_end;
   logic       take;
   logic [2:0] ia;
   logic [2:0] ib;

   assign st        = plan_step(b_item_ff.plan, phase_ff);
   assign next_base = {1'b0, base_ff} + {1'b0, plan_stride(b_item_ff.plan)};
   // border items are a single group; otherwise the group that passes pixel 7
   assign item_end  = b_valid_ff && st.group_end &&
                      (b_item_ff.plan == PLAN_BORDER || next_base[3]);
   assign b_free    = !b_valid_ff || item_end;
   assign take      = a_valid && b_free;

   assign ia = base_ff + {1'b0, st.oa};
   assign ib = base_ff + {1'b0, st.ob};

   always_comb begin
      tap_in.ca   = b_item_ff.bits[ia] ? b_item_ff.ink : b_item_ff.paper;
      tap_in.cb   = b_item_ff.bits[ib] ? b_item_ff.ink : b_item_ff.paper;
      tap_in.op   = st.op;
      tap_in.last = item_end;
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      phase_in   = phase_ff;
      base_in    = base_ff;
      if (take) begin
         b_valid_in = 1'b1;
         phase_in   = '0;
         base_in    = '0;
      end else if (item_end) begin
         b_valid_in = 1'b0;
      end else if (b_valid_ff) begin
         if (st.group_end) begin
            phase_in = '0;
            base_in  = next_base[2:0];
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         phase_ff   <= '0;
         base_ff    <= '0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         phase_ff   <= phase_in;
         base_ff    <= base_in;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_item_ff <= item;
      end
      tap_ff <= tap_in;
   end

   assign c_valid = c_valid_ff;
   assign tap     = tap_ff;

`ifndef NO_ASSERTIONS
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !item_end |=> b_valid_ff)
      else $error("sequencer dropped an item before its last pixel");
   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && phase_ff == 3'd4 |-> st.group_end)
      else $error("group ran past five pixels");
   a_take_resets: assert property (@(posedge clock) disable iff (reset)
      take |=> phase_ff == 3'd0 && base_ff == 3'd0)
      else $error("new item did not start at its first pixel");
`endif

endmodule

// ===== hdl/vwpe_blend.sv =====
// mix stage: pass, masked half or masked quarter average, output register
module vwpe_blend import vwpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               c_valid,
   input  tap_type            tap,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_pixel_color,
   output logic               rsp_last
);

   logic               valid_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [COLOR_W-1:0] color_in;
   logic               last_ff;
   logic [COLOR_W:0]   half_sum;
   logic [COLOR_W-1:0] qa;
   logic [COLOR_W-1:0] qb;
   logic [COLOR_W-1:0] quarter;

   assign half_sum = {1'b0, tap.ca & HALF_MASK} + {1'b0, tap.cb & HALF_MASK};
   assign qa       = (tap.ca & QUARTER_MASK) >> 2;
   assign qb       = (tap.cb & QUARTER_MASK) >> 2;
   assign quarter  = (tap.ca == tap.cb) ? tap.ca : qa + (tap.cb - qb);

   always_comb begin
      case (tap.op)
         OP_HALF:    color_in = half_sum[COLOR_W:1];
         OP_QUARTER: color_in = quarter;
         default:    color_in = tap.ca;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      last_ff  <= tap.last;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last        = last_ff & valid_ff;

endmodule

// ===== hdl/video_word_pixel_expander.sv =====
// top level of the video word pixel expander
//
// An item (attribute word, hires byte or border request) is taken at a clock edge with start
// high and busy low. Its pixels come out one per cycle on rsp_pixel_color, each marked by
// rsp_valid for one cycle, with rsp_last on the final pixel of the item; the receiver cannot
// hold them off, so it must take every valid cycle. The expansion sequencer emits one pixel
// per cycle, and an item yields 1 pixel for a border item, 4/8/10/12/16/20/24 depending on
// scale mode and hires. One more item waits in the input register, so busy rises only while
// both the sequencer and that register are full, and pixels of consecutive items follow
// without a gap. With the sequencer free, the first pixel of an item is registered in turn
// by the input decode, sequencer, color select and output register stages, mixed before the last.
// Configuration must be written only while no pixels are pending (not enforced here).
module video_word_pixel_expander import vwpe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // item transfer
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [15:0]           req_video_word,
   // pixel transfer
   output logic                  rsp_valid,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic                  rsp_last,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   item_type item;
   tap_type  tap;
   logic     a_valid;
   logic     b_free;
   logic     c_valid;
   logic     load;

   // input register frees when the sequencer finishes its item or is empty
   assign busy = a_valid && !b_free;
   assign load = start && !busy;

   vwpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stage 1: palette lookups and plan
   vwpe_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load       (load),
      .func       (req_func),
      .video_word (req_video_word),
      .take       (b_free),
      .a_valid    (a_valid),
      .item       (item)
   );

   // stages 2 and 3: pixel sequencing and color select
   vwpe_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .a_valid (a_valid),
      .item    (item),
      .b_free  (b_free),
      .c_valid (c_valid),
      .tap     (tap)
   );

   // stage 4: mix and output register
   vwpe_blend u_blend (
      .clock           (clock),
      .reset           (reset),
      .c_valid         (c_valid),
      .tap             (tap),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside the pixels of one item");
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      load && a_valid |-> b_free)
      else $error("item loaded over a waiting item");
`endif

endmodule

// ===== verif/video_word_pixel_expander_tb.sv =====
// testbench for the video word pixel expander: directed and random items checked pixel by pixel
`timescale 1ns / 100ps

module video_word_pixel_expander_tb;
   import vwpe_pkg::*;

   // item function codes
   localparam logic FUNC_VIDEO  = 1'b0;
   localparam logic FUNC_BORDER = 1'b1;

   // masks of the neighbour blends, applied on 32 bits before the cut to 24
   localparam logic [31:0] HALF_KEEP    = 32'hFEFEFEFF;
   localparam logic [31:0] QUARTER_KEEP = 32'hFCFCFCFF;

   localparam int ERROR_PRINT_CAP = 40;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_func = FUNC_VIDEO;
   logic [15:0]           req_video_word = '0;
   logic                  rsp_valid;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // our own copy of the palette rom and of the register file
   logic [COLOR_W-1:0] color_rom [0:23];
   cfg_type            shadow_cfg = '0;

   // pixels predicted for accepted items and not yet seen at the output
   pixel_type pending_pixels[$];
   pixel_type want;

   int error_count    = 0;
   int items_sent     = 0;
   int border_items   = 0;
   int hires_items    = 0;
   int pixels_checked = 0;
   int config_count   = 0;
   int idle_pct       = 0;

   video_word_pixel_expander DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_video_word  (req_video_word),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= ERROR_PRINT_CAP)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // masked average of two colors
   function automatic logic [COLOR_W-1:0] mix_half(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      logic [31:0] sum;
      sum = ({8'h00, a} & HALF_KEEP) + ({8'h00, b} & HALF_KEEP);
      return sum[24:1];
   endfunction

   // quarter of a plus three quarters of b, identical colors pass unchanged
   function automatic logic [COLOR_W-1:0] mix_quarter(input logic [COLOR_W-1:0] a,
                                                      input logic [COLOR_W-1:0] b);
      logic [31:0] qa;
      logic [31:0] qb;
      logic [31:0] sum;
      if (a == b)
         return a;
      qa  = ({8'h00, a} & QUARTER_KEEP) >> 2;
      qb  = ({8'h00, b} & QUARTER_KEEP) >> 2;
      sum = qa + ({8'h00, b} - qb);
      return sum[23:0];
   endfunction

   // works out the pixels one accepted item yields and queues them
   function automatic void expand_item(input logic func, input logic [15:0] word);
      logic [COLOR_W-1:0] pix [8];
      logic [COLOR_W-1:0] row_colors [$];
      logic [COLOR_W-1:0] ink;
      logic [COLOR_W-1:0] paper;
      logic [COLOR_W-1:0] swap;
      logic [2:0]         mode;
      int                 i;
      if (func == FUNC_BORDER) begin
         pending_pixels.push_back('{color: color_rom[16 + shadow_cfg.border_color], last: 1'b1});
         return;
      end
      // unused scale modes fall back to 1x
      mode = (shadow_cfg.screen_mode > MODE_BLEND3) ? MODE_1X : shadow_cfg.screen_mode;
      if (shadow_cfg.hires_on) begin
         paper = color_rom[shadow_cfg.border_color];
         ink   = color_rom[shadow_cfg.border_color ^ 3'd7];
      end else begin
         paper = color_rom[word[13:11]];
         ink   = color_rom[word[10:8]];
         if (word[15] && shadow_cfg.blink_phase) begin
            swap  = ink;
            ink   = paper;
            paper = swap;
         end
      end
      // msb is shown first
      for (i = 0; i < 8; i++)
         pix[i] = word[7 - i] ? ink : paper;
      if (shadow_cfg.hires_on) begin
         case (mode)
            MODE_HALF: begin
               for (i = 0; i < 8; i += 2)
                  row_colors.push_back(mix_half(pix[i], pix[i + 1]));
            end
            MODE_BLEND25: begin
               for (i = 0; i < 8; i += 4) begin
                  row_colors.push_back(pix[i]);
                  row_colors.push_back(mix_quarter(pix[i], pix[i + 1]));
                  row_colors.push_back(mix_half(pix[i + 1], pix[i + 2]));
                  row_colors.push_back(mix_quarter(pix[i + 3], pix[i + 2]));
                  row_colors.push_back(pix[i + 3]);
               end
            end
            MODE_BLEND3: begin
               for (i = 0; i < 8; i += 2) begin
                  row_colors.push_back(pix[i]);
                  row_colors.push_back(mix_half(pix[i], pix[i + 1]));
                  row_colors.push_back(pix[i + 1]);
               end
            end
            default: begin
               for (i = 0; i < 8; i++)
                  row_colors.push_back(pix[i]);
            end
         endcase
      end else begin
         case (mode)
            MODE_DOUBLE: begin
               for (i = 0; i < 8; i++)
                  repeat (2) row_colors.push_back(pix[i]);
            end
            MODE_BLEND25: begin
               for (i = 0; i < 8; i += 2) begin
                  repeat (2) row_colors.push_back(pix[i]);
                  row_colors.push_back(mix_half(pix[i], pix[i + 1]));
                  repeat (2) row_colors.push_back(pix[i + 1]);
               end
            end
            MODE_BLEND3: begin
               for (i = 0; i < 8; i++)
                  repeat (3) row_colors.push_back(pix[i]);
            end
            default: begin
               for (i = 0; i < 8; i++)
                  row_colors.push_back(pix[i]);
            end
         endcase
      end
      for (i = 0; i < row_colors.size(); i++)
         pending_pixels.push_back('{color: row_colors[i], last: (i == row_colors.size() - 1)});
   endfunction

   // one item transfer: hold start until an edge sees busy low
   task automatic send_item(input logic func, input logic [15:0] word);
      req_func       <= func;
      req_video_word <= word;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      expand_item(func, word);
      items_sent++;
      if (func == FUNC_BORDER)
         border_items++;
      else if (shadow_cfg.hires_on)
         hires_items++;
   endtask

   // random sender idle cycles before the next item
   task automatic sender_gap();
      int n;
      n = 0;
      while ($urandom_range(0, 99) < idle_pct)
         n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending and let every predicted pixel come out
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      // let the pipeline drain before touching the registers
      repeat (8) @(posedge clock);
   endtask

   // register write (setup, access) followed by a read back of the same register
   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SCREEN_MODE:  shadow_cfg.screen_mode  = value[2:0];
         REG_HIRES_ON:     shadow_cfg.hires_on     = value[0];
         REG_BORDER_COLOR: shadow_cfg.border_color = value[2:0];
         REG_BLINK_PHASE:  shadow_cfg.blink_phase  = value[0];
         default: ;
      endcase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      // bus idles before the next transfer
      @(posedge clock);
      if (got !== value)
         report_error($sformatf("register %s reads %0h, wrote %0h", idx.name(), got, value));
   endtask

   task automatic set_config(input logic [2:0] mode, input logic hires, input logic [2:0] border,
                             input logic blink);
      wait_idle();
      write_csr(REG_SCREEN_MODE, CSR_DATA_W'(mode));
      write_csr(REG_HIRES_ON, CSR_DATA_W'(hires));
      write_csr(REG_BORDER_COLOR, CSR_DATA_W'(border));
      write_csr(REG_BLINK_PHASE, CSR_DATA_W'(blink));
      config_count++;
   endtask

   // pixel checker: every valid cycle is a transfer, compared against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected pixel %06h last %0b", rsp_pixel_color, rsp_last));
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_pixel_color !== want.color)
               report_error($sformatf("pixel color %06h, expected %06h",
                                      rsp_pixel_color, want.color));
            if (rsp_last !== want.last)
               report_error($sformatf("last flag %0b, expected %0b", rsp_last, want.last));
         end
      end
   end

   // reset state: 1x, normal mode, border 0, no blink
   task automatic test_reset_defaults();
      send_item(FUNC_VIDEO, 16'h0000);
      send_item(FUNC_VIDEO, 16'hFFFF);
      // bit 14 carries no meaning in normal mode
      send_item(FUNC_VIDEO, 16'h40A5);
      send_item(FUNC_BORDER, 16'h1234);
   endtask

   // ink and paper swap only with both the cell bit and the blink phase set
   task automatic test_blink();
      set_config(MODE_DOUBLE, 1'b0, 3'd5, 1'b1);
      send_item(FUNC_VIDEO, 16'hBF5A);
      send_item(FUNC_VIDEO, 16'h3F5A);
      send_item(FUNC_VIDEO, 16'h8000);
      set_config(MODE_1X, 1'b0, 3'd7, 1'b0);
      send_item(FUNC_VIDEO, 16'hBF5A);
   endtask

   // remaining normal-mode scalings, unused mode codes included
   task automatic test_scale_modes();
      set_config(MODE_HALF, 1'b0, 3'd1, 1'b0);
      send_item(FUNC_VIDEO, 16'h1E96);
      set_config(MODE_BLEND25, 1'b0, 3'd2, 1'b1);
      send_item(FUNC_VIDEO, 16'hA3C9);
      set_config(MODE_BLEND3, 1'b0, 3'd6, 1'b0);
      send_item(FUNC_VIDEO, 16'h2B3C);
      send_item(FUNC_BORDER, 16'hFFFF);
      set_config(3'd5, 1'b0, 3'd3, 1'b0);
      send_item(FUNC_VIDEO, 16'h0D69);
      set_config(3'd7, 1'b0, 3'd4, 1'b0);
      send_item(FUNC_VIDEO, 16'h35F0);
   endtask

   // hires: byte items, colors from the border register, upper byte ignored
   task automatic test_hires();
      logic [15:0] words [6];
      logic [2:0]  modes [6];
      int          i;
      words = '{16'hFF3C, 16'h00A5, 16'h5A0F, 16'h00F0, 16'hAA96, 16'h0081};
      modes = '{MODE_1X, MODE_HALF, MODE_DOUBLE, MODE_BLEND25, MODE_BLEND3, 3'd6};
      for (i = 0; i < 6; i++) begin
         set_config(modes[i], 1'b1, (i % 2 == 0) ? 3'd0 : 3'd7, i[0]);
         send_item(FUNC_VIDEO, words[i]);
      end
      send_item(FUNC_BORDER, 16'h0000);
   endtask

   // random settings and items, with the sender idling at the given rate
   task automatic test_random_traffic(input int sender_idle_pct);
      int          seg;
      int          n;
      logic [2:0]  mode;
      logic [15:0] word;
      idle_pct = sender_idle_pct;
      for (seg = 0; seg < 8; seg++) begin
         mode = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
         set_config(mode, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
         n = $urandom_range(11, 19);
         repeat (n) begin
            sender_gap();
            word = 16'($urandom_range(0, 65535));
            send_item(($urandom_range(0, 9) == 0) ? FUNC_BORDER : FUNC_VIDEO, word);
         end
      end
      idle_pct = 0;
   endtask

   initial begin
      color_rom = '{24'h000000, 24'h0000FF, 24'hFF0000, 24'hFF00FF,
                    24'h00FF00, 24'h00FFFF, 24'hFFFF00, 24'hFFFFFF,
                    24'h000000, 24'h00007F, 24'h7F0000, 24'h7F007F,
                    24'h007F00, 24'h007F7F, 24'h7F7F00, 24'h7F7F7F,
                    24'h101010, 24'h0000EF, 24'hEF0000, 24'hEF00EF,
                    24'h00EF00, 24'h00EFEF, 24'hEFEF00, 24'hEFEFEF};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_blink();
      test_scale_modes();
      test_hires();
      // before each item the sender keeps adding idle cycles with a 25, then 49, then 0 percent chance
      test_random_traffic(25);
      test_random_traffic(49);
      test_random_traffic(0);

      wait_idle();
      $display("run covered %0d items (%0d border, %0d hires) under %0d register settings",
               items_sent, border_items, hires_items, config_count);
      $display("%0d pixels compared, %0d mismatches", pixels_checked, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d pixels still pending", pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/vwpe_pkg.sv
hdl/vwpe_csr.sv
hdl/vwpe_decode.sv
hdl/vwpe_seq.sv
hdl/vwpe_blend.sv
hdl/video_word_pixel_expander.sv
verif/video_word_pixel_expander_tb.sv
